### rtl/tpf_pkg.sv
`default_nettype none
package tpf_pkg;

  localparam int unsigned SampleW = 12;
  localparam int unsigned PosW    = 10;
  localparam int unsigned PressW  = 16;
  localparam int unsigned RegW    = 16;

  typedef struct packed {
    logic [SampleW-1:0] x_sample_0;
    logic [SampleW-1:0] x_sample_1;
    logic [SampleW-1:0] x_sample_2;
    logic [SampleW-1:0] x_sample_3;
    logic [SampleW-1:0] y_sample_0;
    logic [SampleW-1:0] y_sample_1;
    logic [SampleW-1:0] y_sample_2;
    logic [SampleW-1:0] y_sample_3;
    logic [SampleW-1:0] press_low;
    logic [SampleW-1:0] press_high;
  } tpf_in_t;

  typedef struct packed {
    logic [PosW-1:0]          x_pos;
    logic [PosW-1:0]          y_pos;
    logic signed [PressW-1:0] pressure;
    logic                     valid_res;
    logic                     press_fault;
  } tpf_out_t;

  typedef struct packed {
    logic full;
    logic empty;
  } tpf_qstat_t;

endpackage
`default_nettype wire

### rtl/tpf_queue.sv
`default_nettype none
module tpf_queue #(
  parameter int unsigned W = 8
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         wr_i,
  input  wire logic [W-1:0] wdata_i,
  input  wire logic         rd_i,
  output logic [W-1:0]      rdata_o,
  output tpf_pkg::tpf_qstat_t stat_o
);
  import tpf_pkg::*;

  logic [W-1:0] mem_q [2];
  logic         wptr_q, rptr_q;
  logic [1:0]   cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (wr_i) wptr_q <= ~wptr_q;
      if (rd_i) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + 2'(wr_i) - 2'(rd_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wptr_q] <= wdata_i;
  end

  assign rdata_o      = mem_q[rptr_q];
  assign stat_o.full  = cnt_q[1];
  assign stat_o.empty = (cnt_q == 2'd0);
endmodule
`default_nettype wire

### rtl/tpf_div.sv
`default_nettype none
module tpf_div #(
  parameter int unsigned NW = 16,
  parameter int unsigned DW = 16,
  parameter int unsigned SW = 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  input  wire logic [SW-1:0] side_i,
  output logic               valid_o,
  output logic [NW-1:0]      quo_o,
  output logic [SW-1:0]      side_o
);
  import tpf_pkg::*;

  // one quotient bit per stage; numerator bits shift out as quotient bits shift in
  logic [NW-1:0] num_q  [NW];
  logic [DW-1:0] rem_q  [NW];
  logic [DW-1:0] den_q  [NW];
  logic [SW-1:0] side_q [NW];
  logic          vld_q  [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [NW-1:0] n_in;
    logic [DW-1:0] r_in, d_in;
    logic [SW-1:0] s_in;
    logic          v_in;
    logic [DW:0]   t;
    logic          qb;
    logic [DW-1:0] r_d;

    if (k == 0) begin : g_first
      assign n_in = num_i;
      assign r_in = '0;
      assign d_in = den_i;
      assign s_in = side_i;
      assign v_in = valid_i;
    end else begin : g_next
      assign n_in = num_q[k-1];
      assign r_in = rem_q[k-1];
      assign d_in = den_q[k-1];
      assign s_in = side_q[k-1];
      assign v_in = vld_q[k-1];
    end

    always_comb begin
      t  = {r_in, n_in[NW-1]};
      qb = (t >= {1'b0, d_in});
      r_d = qb ? DW'(t - {1'b0, d_in}) : t[DW-1:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[k]  <= {n_in[NW-2:0], qb};
        rem_q[k]  <= r_d;
        den_q[k]  <= d_in;
        side_q[k] <= s_in;
      end
    end
  end

  assign valid_o = vld_q[NW-1];
  assign quo_o   = num_q[NW-1];
  assign side_o  = side_q[NW-1];
endmodule
`default_nettype wire

### rtl/tpf_front.sv
`default_nettype none
module tpf_front #(
  parameter int unsigned ADC_FULL_SCALE = 4095,
  parameter int unsigned JW = 8
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   push_i,
  input  wire tpf_pkg::tpf_in_t       in_i,
  input  wire logic [tpf_pkg::RegW-1:0] pr_i,
  input  wire tpf_pkg::tpf_qstat_t    qstat_i,
  output logic                        ready_o,
  output logic                        job_wr_o,
  output logic [JW-1:0]               job_o
);
  import tpf_pkg::*;

  localparam int unsigned AW = $clog2(ADC_FULL_SCALE + 1);
  localparam int unsigned LW = (AW > SampleW) ? AW : SampleW;
  localparam int unsigned MW = LW + 1;
  localparam int unsigned M1W = SampleW + AW;
  localparam int unsigned NW = M1W + RegW;

  typedef struct packed {
    logic [SampleW-1:0] mid;
    logic [SampleW-1:0] top;
  } sort_t;

  function automatic sort_t sort4(input logic [SampleW-1:0] a, b, c, d);
    logic [SampleW-1:0] v0, v1, v2, v3, t;
    sort_t r;
    v0 = a; v1 = b; v2 = c; v3 = d;
    if (v0 > v1) begin t = v0; v0 = v1; v1 = t; end
    if (v2 > v3) begin t = v2; v2 = v3; v3 = t; end
    if (v0 > v2) begin t = v0; v0 = v2; v2 = t; end
    if (v1 > v3) begin t = v1; v1 = v3; v3 = t; end
    if (v1 > v2) begin t = v1; v1 = v2; v2 = t; end
    r.mid = v2;
    r.top = v3;
    return r;
  endfunction

  function automatic logic [AW-1:0] axis_val(input logic [SampleW-1:0] mid);
    logic [LW-1:0] m;
    logic [LW-1:0] v;
    m = LW'(mid);
    v = (m > LW'(ADC_FULL_SCALE)) ? '0 : LW'(ADC_FULL_SCALE) - m;
    return v[AW-1:0];
  endfunction

  logic en;
  logic v1_q, v2_q, v3_q;

  // stage 1: sort, axis values, pressure classification
  sort_t xs, ys;
  logic signed [SampleW:0] dz;
  logic signed [LW+1:0]    zs;
  logic                    res;

  logic [AW-1:0]      xv1_q, yv1_q;
  logic               ok1_q, simp1_q, flt1_q, neg1_q;
  logic [MW-1:0]      smag1_q;
  logic [SampleW-1:0] dmag1_q, z1_1_q;

  // stage 2
  logic [AW-1:0]  xv2_q, yv2_q;
  logic           ok2_q, simp2_q, flt2_q, neg2_q;
  logic [MW-1:0]  smag2_q;
  logic [M1W-1:0] m1_q, den2_q;

  // stage 3
  logic [AW-1:0]  xv3_q, yv3_q;
  logic           ok3_q, simp3_q, flt3_q, neg3_q;
  logic [MW-1:0]  smag3_q;
  logic [NW-1:0]  m2_q;
  logic [M1W-1:0] den3_q;

  assign en      = !v3_q || !qstat_i.full;
  assign ready_o = en;

  always_comb begin
    xs  = sort4(in_i.x_sample_0, in_i.x_sample_1, in_i.x_sample_2, in_i.x_sample_3);
    ys  = sort4(in_i.y_sample_0, in_i.y_sample_1, in_i.y_sample_2, in_i.y_sample_3);
    dz  = $signed({1'b0, in_i.press_high}) - $signed({1'b0, in_i.press_low});
    zs  = $signed({2'b00, LW'(ADC_FULL_SCALE)}) - (LW+2)'(dz);
    res = (pr_i != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= push_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      xv1_q   <= axis_val(xs.mid);
      yv1_q   <= axis_val(ys.mid);
      ok1_q   <= ((xs.top - xs.mid) <= SampleW'(2)) && ((ys.top - ys.mid) <= SampleW'(2));
      simp1_q <= !res;
      flt1_q  <= res && (in_i.press_low == '0);
      neg1_q  <= res ? dz[SampleW] : zs[LW+1];
      smag1_q <= zs[LW+1] ? MW'(-zs) : MW'(zs);
      dmag1_q <= dz[SampleW] ? SampleW'(-dz) : dz[SampleW-1:0];
      z1_1_q  <= in_i.press_low;

      xv2_q   <= xv1_q;
      yv2_q   <= yv1_q;
      ok2_q   <= ok1_q;
      simp2_q <= simp1_q;
      flt2_q  <= flt1_q;
      neg2_q  <= neg1_q;
      smag2_q <= smag1_q;
      m1_q    <= M1W'(dmag1_q) * M1W'(xv1_q);
      den2_q  <= M1W'(z1_1_q) * M1W'(ADC_FULL_SCALE);

      xv3_q   <= xv2_q;
      yv3_q   <= yv2_q;
      ok3_q   <= ok2_q;
      simp3_q <= simp2_q;
      flt3_q  <= flt2_q;
      neg3_q  <= neg2_q;
      smag3_q <= smag2_q;
      m2_q    <= NW'(m1_q) * NW'(pr_i);
      den3_q  <= den2_q;
    end
  end

  assign job_wr_o = v3_q && !qstat_i.full;
  assign job_o = JW'({ok3_q, simp3_q, flt3_q, neg3_q, smag3_q, xv3_q, yv3_q, m2_q, den3_q});
endmodule
`default_nettype wire

### rtl/tpf_back.sv
`default_nettype none
module tpf_back #(
  parameter int unsigned ADC_FULL_SCALE = 4095,
  parameter int unsigned OUT_FULL_SCALE = 1023,
  parameter int unsigned JW = 8
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire tpf_pkg::tpf_qstat_t qstat_i,
  input  wire logic [JW-1:0]       job_i,
  output logic                     job_rd_o,
  input  wire logic                pop_i,
  output logic                     empty_o,
  output tpf_pkg::tpf_out_t        out_o
);
  import tpf_pkg::*;

  localparam int unsigned AW  = $clog2(ADC_FULL_SCALE + 1);
  localparam int unsigned OW  = $clog2(OUT_FULL_SCALE + 1);
  localparam int unsigned LW  = (AW > SampleW) ? AW : SampleW;
  localparam int unsigned MW  = LW + 1;
  localparam int unsigned M1W = SampleW + AW;
  localparam int unsigned NW  = M1W + RegW;
  // any |z| at or above this scales past the 16-bit saturation point
  localparam longint unsigned ZCap = (64'd32768 * ADC_FULL_SCALE) / OUT_FULL_SCALE + 64'd1;
  localparam int unsigned CW  = $clog2(ZCap + 1);
  localparam int unsigned PW  = CW + OW;
  localparam int unsigned XW  = AW + OW;
  localparam int unsigned KW  = (PW > XW) ? PW : XW;
  localparam int unsigned SW1 = 4 + MW + 2 * AW;
  // floor(2^KW / full scale): the estimate is exact or one short for any KW-bit numerator
  localparam logic [KW-1:0] RecipM = KW'((64'd1 << KW) / ADC_FULL_SCALE);

  logic en;
  logic out_v_q;
  tpf_out_t out_q;

  logic           j_ok, j_simp, j_flt, j_neg;
  logic [MW-1:0]  j_smag;
  logic [AW-1:0]  j_xv, j_yv;
  logic [NW-1:0]  j_num;
  logic [M1W-1:0] j_den;

  assign {j_ok, j_simp, j_flt, j_neg, j_smag, j_xv, j_yv, j_num, j_den} =
    job_i[NW+M1W+MW+2*AW+3:0];

  assign en       = !out_v_q || pop_i;
  assign job_rd_o = en && !qstat_i.empty;

  // pressure quotient
  logic           d1_v;
  logic [NW-1:0]  d1_q;
  logic [SW1-1:0] d1_s;

  tpf_div #(.NW(NW), .DW(M1W), .SW(SW1)) u_div_press (
    .clk_i, .rst_ni, .en_i(en), .valid_i(!qstat_i.empty),
    .num_i(j_num), .den_i(j_den),
    .side_i({j_ok, j_simp, j_flt, j_neg, j_smag, j_xv, j_yv}),
    .valid_o(d1_v), .quo_o(d1_q), .side_o(d1_s)
  );

  logic          s_ok, s_simp, s_flt, s_neg;
  logic [MW-1:0] s_smag;
  logic [AW-1:0] s_xv, s_yv;
  logic [NW-1:0] zsel;
  assign {s_ok, s_simp, s_flt, s_neg, s_smag, s_xv, s_yv} = d1_s;
  assign zsel = s_simp ? NW'(s_smag) : d1_q;

  // clamp, then scale multiply
  logic          b_v_q, c_v_q;
  logic          b_ok_q, b_flt_q, b_neg_q, c_ok_q, c_flt_q, c_neg_q;
  logic [CW-1:0] b_z_q;
  logic [AW-1:0] b_xv_q, b_yv_q;
  logic [KW-1:0] c_pm_q, c_xm_q, c_ym_q;

  // divide by full scale, three lanes in lockstep: reciprocal estimate, then fix-up
  logic            d_v_q, e_v_q;
  logic            d_ok_q, d_flt_q, d_neg_q, e_ok_q, e_flt_q, e_neg_q;
  logic [KW-1:0]   c_m [3];
  logic [2*KW-1:0] d_prod_q [3];
  logic [KW-1:0]   d_n_q [3];
  logic [KW-1:0]   q_est [3];
  logic [KW-1:0]   r_est [3];
  logic [KW-1:0]   e_q_q [3];
  logic [AW:0]     e_r_q [3];
  logic [KW-1:0]   q_fin [3];

  assign c_m[0] = c_pm_q;
  assign c_m[1] = c_xm_q;
  assign c_m[2] = c_ym_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q_est[i] = d_prod_q[i][2*KW-1:KW];
      r_est[i] = d_n_q[i] - q_est[i] * KW'(ADC_FULL_SCALE);
      q_fin[i] = e_q_q[i] + KW'(e_r_q[i] >= (AW+1)'(ADC_FULL_SCALE));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      d_v_q <= 1'b0;
      e_v_q <= 1'b0;
    end else if (en) begin
      b_v_q <= d1_v;
      c_v_q <= b_v_q;
      d_v_q <= c_v_q;
      e_v_q <= d_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_ok_q  <= s_ok;
      b_flt_q <= s_flt;
      b_neg_q <= s_neg;
      b_z_q   <= (zsel > NW'(ZCap)) ? CW'(ZCap) : zsel[CW-1:0];
      b_xv_q  <= s_xv;
      b_yv_q  <= s_yv;

      c_ok_q  <= b_ok_q;
      c_flt_q <= b_flt_q;
      c_neg_q <= b_neg_q;
      c_pm_q  <= KW'(b_z_q) * KW'(OUT_FULL_SCALE);
      c_xm_q  <= KW'(b_xv_q) * KW'(OUT_FULL_SCALE);
      c_ym_q  <= KW'(b_yv_q) * KW'(OUT_FULL_SCALE);

      d_ok_q  <= c_ok_q;
      d_flt_q <= c_flt_q;
      d_neg_q <= c_neg_q;
      e_ok_q  <= d_ok_q;
      e_flt_q <= d_flt_q;
      e_neg_q <= d_neg_q;
      for (int i = 0; i < 3; i++) begin
        d_prod_q[i] <= (2*KW)'(c_m[i]) * (2*KW)'(RecipM);
        d_n_q[i]    <= c_m[i];
        e_q_q[i]    <= q_est[i];
        e_r_q[i]    <= r_est[i][AW:0];
      end
    end
  end

  tpf_out_t res_d;
  logic [KW-1:0] ydiff;

  always_comb begin
    ydiff = KW'(OUT_FULL_SCALE) - q_fin[2];
    res_d.x_pos       = q_fin[1][PosW-1:0];
    res_d.y_pos       = ydiff[PosW-1:0];
    res_d.valid_res   = e_ok_q;
    res_d.press_fault = e_flt_q;
    if (e_flt_q) begin
      res_d.pressure = 16'sh7fff;
    end else if (!e_neg_q) begin
      res_d.pressure = (q_fin[0] > KW'(32767)) ? 16'sh7fff : PressW'(q_fin[0]);
    end else begin
      res_d.pressure = (q_fin[0] > KW'(32768)) ? 16'sh8000 : PressW'(-q_fin[0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= e_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) out_q <= res_d;
  end

  assign empty_o = !out_v_q;
  assign out_o   = out_q;
endmodule
`default_nettype wire

### rtl/touch_panel_point_filter_core.sv
// Pipeline: 49 register stages:
//   3 front + 1 queue + NW pressure-divider stages (NW = 28 + adc bits, 40 by default)
//   + 2 scale + 2 reciprocal-divide stages + 1 output register.
// Throughput: one request per cycle; full rises only when the queue and front are backed up.
// Front and back stall independently around a two-entry queue.
// Reset: asynchronous, active low; clears valid bits and sets the plate-resistance register pr_q to 0.
`default_nettype none
module touch_panel_point_filter_core #(
  parameter int unsigned ADC_FULL_SCALE = 4095,
  parameter int unsigned OUT_FULL_SCALE = 1023
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     push,
  output logic                          full,
  input  wire tpf_pkg::tpf_in_t         in_i,
  output logic                          empty,
  input  wire logic                     pop,
  output tpf_pkg::tpf_out_t             out_o,
  input  wire logic                     cfg_we_i,
  input  wire logic [tpf_pkg::RegW-1:0] cfg_wdata_i
);
  import tpf_pkg::*;

  localparam int unsigned AW  = $clog2(ADC_FULL_SCALE + 1);
  localparam int unsigned LW  = (AW > SampleW) ? AW : SampleW;
  localparam int unsigned MW  = LW + 1;
  localparam int unsigned M1W = SampleW + AW;
  localparam int unsigned NW  = M1W + RegW;
  localparam int unsigned JW  = 4 + MW + 2 * AW + NW + M1W;

  logic [RegW-1:0] pr_q;
  logic            ready, job_wr, job_rd;
  logic [JW-1:0]   job_w, job_r;
  tpf_qstat_t      qstat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pr_q <= '0;
    end else if (cfg_we_i) begin
      pr_q <= cfg_wdata_i;
    end
  end

  tpf_front #(.ADC_FULL_SCALE(ADC_FULL_SCALE), .JW(JW)) u_front (
    .clk_i, .rst_ni, .push_i(push), .in_i, .pr_i(pr_q), .qstat_i(qstat),
    .ready_o(ready), .job_wr_o(job_wr), .job_o(job_w)
  );

  tpf_queue #(.W(JW)) u_queue (
    .clk_i, .rst_ni, .wr_i(job_wr), .wdata_i(job_w), .rd_i(job_rd),
    .rdata_o(job_r), .stat_o(qstat)
  );

  tpf_back #(
    .ADC_FULL_SCALE(ADC_FULL_SCALE), .OUT_FULL_SCALE(OUT_FULL_SCALE), .JW(JW)
  ) u_back (
    .clk_i, .rst_ni, .qstat_i(qstat), .job_i(job_r), .job_rd_o(job_rd),
    .pop_i(pop), .empty_o(empty), .out_o
  );

  assign full = !ready;

  a_full_needs_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> qstat.full) else $error("front stalled while queue has room");

  a_fault_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_o.press_fault) |-> (out_o.pressure == 16'sh7fff))
    else $error("pressure fault without saturated pressure");

  a_no_write_empty_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qstat.full |-> !qstat.empty) else $error("queue status inconsistent");
endmodule
`default_nettype wire

### test/tb_touch_panel_point_filter_core.sv
module tb_touch_panel_point_filter_core;
  import tpf_pkg::*;

  localparam int AdcFs = 4095;
  localparam int OutFs = 1023;
  localparam int unsigned PipeDepth = 80;
  localparam longint unsigned CycleLimit = 2000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  tpf_in_t in_i = '0;
  logic empty;
  logic pop = 1'b0;
  tpf_out_t out_o;
  logic cfg_we_i = 1'b0;
  logic [RegW-1:0] cfg_wdata_i = '0;

  touch_panel_point_filter_core i_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .push(push),
    .full(full),
    .in_i(in_i),
    .empty(empty),
    .pop(pop),
    .out_o(out_o),
    .cfg_we_i(cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  tpf_in_t pending_readings[$];
  tpf_out_t expected_points[$];
  logic [RegW-1:0] plate_res;
  int errors = 0;
  longint unsigned cycles = 0;
  int send_gap = 0;
  int recv_gap = 0;
  bit hold_send = 1'b0;
  bit cfg_req = 1'b0;
  logic [RegW-1:0] cfg_val;

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // full scale minus upper median of four; ok when top two within 2
  function automatic longint median_axis(input logic [SampleW-1:0] s0, s1, s2, s3,
                                         output bit ok);
    logic [SampleW-1:0] v[4];
    logic [SampleW-1:0] t;
    v[0] = s0; v[1] = s1; v[2] = s2; v[3] = s3;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3 - i; j++)
        if (v[j] > v[j+1]) begin
          t = v[j]; v[j] = v[j+1]; v[j+1] = t;
        end
    ok = (v[3] - v[2]) <= 2;
    return AdcFs - longint'(v[2]);
  endfunction

  function automatic tpf_out_t predict_point(input tpf_in_t r);
    tpf_out_t o;
    bit okx, oky;
    longint xv, yv, z1, z2, z, p;
    xv = median_axis(r.x_sample_0, r.x_sample_1, r.x_sample_2, r.x_sample_3, okx);
    yv = median_axis(r.y_sample_0, r.y_sample_1, r.y_sample_2, r.y_sample_3, oky);
    z1 = r.press_low;
    z2 = r.press_high;
    o.press_fault = 1'b0;
    if (plate_res != 0) begin
      if (z1 == 0) begin
        o.press_fault = 1'b1;
        p = 32767;
      end else begin
        z = ((z2 - z1) * xv * longint'(plate_res)) / (z1 * AdcFs);
        p = z * OutFs / AdcFs;
      end
    end else begin
      z = AdcFs - (z2 - z1);
      p = z * OutFs / AdcFs;
    end
    if (p > 32767) p = 32767;
    if (p < -32768) p = -32768;
    o.x_pos = PosW'(xv * OutFs / AdcFs);
    o.y_pos = PosW'(OutFs - yv * OutFs / AdcFs);
    o.pressure = PressW'(p);
    o.valid_res = okx & oky;
    return o;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint exp);
    $display("mismatch %s: got %0d expected %0d", what, got, exp);
    errors++;
  endtask

  // driver
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    cfg_we_i <= cfg_req && !cfg_we_i;
    if (push && !full) begin
      expected_points.push_back(predict_point(in_i));
      void'(pending_readings.pop_front());
    end
    if (cfg_req && !cfg_we_i) begin
      cfg_wdata_i <= cfg_val;
      plate_res <= cfg_val;
      cfg_req <= 1'b0;
      push <= 1'b0;
    end else if (push && full) begin
      push <= 1'b1;
    end else begin
      if (send_gap > 0) send_gap <= send_gap - 1;
      if (!hold_send && send_gap == 0 && pending_readings.size() > 0) begin
        push <= 1'b1;
        in_i <= pending_readings[0];
        send_gap <= draw_gap();
      end else begin
        push <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    tpf_out_t e;
    if (pop && !empty) begin
      if (expected_points.size() == 0) begin
        report_mismatch("unexpected point", 1, 0);
      end else begin
        e = expected_points.pop_front();
        if (out_o.x_pos !== e.x_pos) report_mismatch("x_pos", out_o.x_pos, e.x_pos);
        if (out_o.y_pos !== e.y_pos) report_mismatch("y_pos", out_o.y_pos, e.y_pos);
        if (out_o.pressure !== e.pressure)
          report_mismatch("pressure", out_o.pressure, e.pressure);
        if (out_o.valid_res !== e.valid_res)
          report_mismatch("valid_res", out_o.valid_res, e.valid_res);
        if (out_o.press_fault !== e.press_fault)
          report_mismatch("press_fault", out_o.press_fault, e.press_fault);
      end
    end
    if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
      if ($urandom_range(0, 9) == 0) recv_gap <= draw_gap();
    end
  end

  always @(posedge clk_i) begin
    if (cycles > CycleLimit) begin
      $display("tb_touch_panel_point_filter_core NOT OK");
      $finish;
    end
  end

  function automatic tpf_in_t rand_reading(input int mode);
    tpf_in_t r;
    logic [SampleW-1:0] base;
    r = tpf_in_t'($bits(tpf_in_t)'({$urandom, $urandom, $urandom, $urandom}));
    if (mode == 1) begin
      // tight cluster so spread check passes often
      base = SampleW'($urandom_range(0, 4095));
      r.x_sample_0 = base; r.x_sample_1 = SampleW'(base + $urandom_range(0, 3));
      r.x_sample_2 = SampleW'(base - $urandom_range(0, 2));
      r.x_sample_3 = SampleW'(base + $urandom_range(0, 2));
      base = SampleW'($urandom_range(0, 4095));
      r.y_sample_0 = SampleW'(base + $urandom_range(0, 2)); r.y_sample_1 = base;
      r.y_sample_2 = SampleW'(base - $urandom_range(0, 3));
      r.y_sample_3 = SampleW'(base + $urandom_range(0, 1));
    end
    if ($urandom_range(0, 15) == 0) r.press_low = '0;
    return r;
  endfunction

  task automatic drain();
    while (pending_readings.size() != 0 || push) @(posedge clk_i);
    while (expected_points.size() != 0) @(posedge clk_i);
    repeat (PipeDepth) @(posedge clk_i);
  endtask

  task automatic write_plate(input logic [RegW-1:0] v);
    @(posedge clk_i);
    cfg_val <= v;
    cfg_req <= 1'b1;
    @(posedge clk_i);
    wait (!cfg_req);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic directed_set();
    tpf_in_t r;
    r = '0; pending_readings.push_back(r);
    r = '1; pending_readings.push_back(r);
    r = '0; r.press_low = 12'd4095; pending_readings.push_back(r);
    r = '0; r.press_high = 12'd4095; r.press_low = 12'd1; pending_readings.push_back(r);
    r = '0;
    r.x_sample_0 = 12'd100; r.x_sample_1 = 12'd103; r.x_sample_2 = 12'd90; r.x_sample_3 = 12'd101;
    r.y_sample_0 = 12'd4095; r.y_sample_1 = 12'd4093; r.y_sample_2 = 12'd0;
    r.y_sample_3 = 12'd4094; r.press_low = 12'd1; r.press_high = 12'd4095;
    pending_readings.push_back(r);
    r.x_sample_1 = 12'd102; r.press_low = 12'd4095; r.press_high = 12'd0;
    pending_readings.push_back(r);
    r = '1; r.press_low = 12'd0; pending_readings.push_back(r);
    r.press_low = 12'd1; r.press_high = 12'd4095; r.x_sample_2 = 12'd0;
    r.x_sample_0 = 12'd0; r.x_sample_1 = 12'd0; r.x_sample_3 = 12'd0;
    pending_readings.push_back(r);
    for (int i = 0; i < 4; i++) pending_readings.push_back(rand_reading(i & 1));
  endtask

  initial begin
    logic [RegW-1:0] plates[5];
    plates[0] = 16'd0; plates[1] = 16'hFFFF; plates[2] = 16'd1;
    plates[3] = 16'd300; plates[4] = 16'd0;
    plate_res = '0;
    cfg_val = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    for (int ph = 0; ph < 5; ph++) begin
      write_plate(ph == 0 ? RegW'($urandom) : plates[ph]);
      if (ph == 0) write_plate(plates[0]);
      directed_set();
      for (int i = 0; i < 230; i++) begin
        pending_readings.push_back(rand_reading(int'($urandom_range(0, 3) != 0)));
        if (ph == 2 && i == 100) begin
          while (pending_readings.size() != 0 || push) @(posedge clk_i);
          hold_send = 1'b1;
          while (expected_points.size() != 0) @(posedge clk_i);
          hold_send = 1'b0;
        end
      end
      drain();
    end
    if (errors == 0) begin
      $display("tb_touch_panel_point_filter_core OK");
    end else begin
      $display("tb_touch_panel_point_filter_core NOT OK");
    end
    $finish;
  end

endmodule

### touch_panel_point_filter_core.f
rtl/tpf_pkg.sv
rtl/tpf_queue.sv
rtl/tpf_div.sv
rtl/tpf_front.sv
rtl/tpf_back.sv
rtl/touch_panel_point_filter_core.sv
test/tb_touch_panel_point_filter_core.sv
